/* rtl/core/ppct_pkg.sv */
package ppct_pkg;

  localparam int unsigned PERM_W    = 40;
  localparam int unsigned CODE_W    = 41;
  localparam int unsigned NIB_W     = 4;
  localparam int unsigned NIBBLES   = PERM_W / NIB_W;
  localparam int unsigned PALETTE_N = 4;
  localparam int unsigned CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_3 = 2'd3;

  typedef logic [CODE_W-1:0] code_t;

  typedef struct packed {
    logic [PERM_W-1:0] left_perm;
    logic [PERM_W-1:0] right_perm;
  } in_word_t;

  typedef struct packed {
    code_t          cycle_code;
    logic           palette_hit;
    logic [1:0]     hit_index;
    logic           bad_perm;
  } out_word_t;

endpackage

/* rtl/core/perm_pair_cycle_type_check.sv */
// channel  | direction | handshake               | payload
// in       | input     | in_valid_i / in_stall_o   | in_word_i  (left_perm, right_perm)
// out      | output    | out_valid_o / out_stall_i | out_word_o (cycle_code, palette_hit,
//          |           |                         |             hit_index, bad_perm)
// cfg      | input     | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// one word in and one word out per cycle when nothing stalls
// registers in order: front check and inversion, one orbit hop per
// walk stage for POINTS stages, cycle counting, palette compare into the output
// register
// rst_ni clears every stage valid bit and the palette registers asynchronously
// each stage holds its word while the next one is full and cannot move, so
// bubbles collapse and the input keeps taking words while a result waits
module perm_pair_cycle_type_check #(
  parameter int unsigned POINTS = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  ppct_pkg::in_word_t                  in_word_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output ppct_pkg::out_word_t                 out_word_o,
  input  logic                                cfg_we_i,
  input  logic [ppct_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ppct_pkg::CODE_W-1:0]         cfg_data_i
);

  localparam int unsigned IDXW = $clog2(POINTS);
  localparam int unsigned LENW = $clog2(POINTS + 1);

  // palette registers
  logic [ppct_pkg::PALETTE_N-1:0][ppct_pkg::CODE_W-1:0] palette_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      palette_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ppct_pkg::CFG_PALETTE_0: palette_q[0] <= cfg_data_i;
        ppct_pkg::CFG_PALETTE_1: palette_q[1] <= cfg_data_i;
        ppct_pkg::CFG_PALETTE_2: palette_q[2] <= cfg_data_i;
        ppct_pkg::CFG_PALETTE_3: palette_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // walk pipeline: stage 0 is the front, stage k has taken k hops
  logic [POINTS:0]                    walk_vld_q;
  logic [POINTS:0]                    walk_rdy;
  logic [POINTS-1:0][IDXW-1:0]        rel_q  [POINTS+1];
  logic [POINTS-1:0][IDXW-1:0]        cur_q  [POINTS+1];
  logic [POINTS-1:0][LENW-1:0]        len_q  [POINTS+1];
  logic [POINTS-1:0]                  lead_q [POINTS+1];
  logic [POINTS:0]                    bad_q;

  logic                               cnt_vld_q;
  logic                               cnt_rdy;
  ppct_pkg::code_t                    code_q;
  logic                               cnt_bad_q;

  logic                               out_vld_q;
  logic                               out_rdy;
  ppct_pkg::out_word_t                out_word_q;

  // ready chain from the output back to the input
  assign out_rdy = !out_vld_q || !out_stall_i;
  assign cnt_rdy = !cnt_vld_q || out_rdy;
  assign walk_rdy[POINTS] = !walk_vld_q[POINTS] || cnt_rdy;
  for (genvar k = 0; k < POINTS; k++) begin : g_rdy
    assign walk_rdy[k] = !walk_vld_q[k] || walk_rdy[k+1];
  end
  assign in_stall_o = !walk_rdy[0];

  // front: bijection check, inverse and relative permutation
  logic [POINTS-1:0][IDXW-1:0] front_rel;
  logic                        front_bad;
  logic [POINTS-1:0][IDXW-1:0] lane_home;

  ppct_front #(.POINTS(POINTS)) u_front (
    .word_i (in_word_i),
    .rel_o  (front_rel),
    .bad_o  (front_bad)
  );

  // each lane starts at its own point
  always_comb begin
    for (int p = 0; p < POINTS; p++) lane_home[p] = IDXW'(p);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_vld_q[0] <= 1'b0;
    end else if (walk_rdy[0]) begin
      walk_vld_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (walk_rdy[0] && in_valid_i) begin
      rel_q[0]  <= front_rel;
      cur_q[0]  <= lane_home;
      len_q[0]  <= '0;
      lead_q[0] <= '1;
      bad_q[0]  <= front_bad;
    end
  end

  // walk stages: every lane hops once per stage
  for (genvar k = 1; k <= POINTS; k++) begin : g_walk
    logic [POINTS-1:0][IDXW-1:0] cur_d;
    logic [POINTS-1:0][LENW-1:0] len_d;
    logic [POINTS-1:0]           lead_d;

    ppct_step #(.POINTS(POINTS), .STEP(k)) u_step (
      .rel_i  (rel_q[k-1]),
      .cur_i  (cur_q[k-1]),
      .len_i  (len_q[k-1]),
      .lead_i (lead_q[k-1]),
      .cur_o  (cur_d),
      .len_o  (len_d),
      .lead_o (lead_d)
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        walk_vld_q[k] <= 1'b0;
      end else if (walk_rdy[k]) begin
        walk_vld_q[k] <= walk_vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (walk_rdy[k] && walk_vld_q[k-1]) begin
        rel_q[k]  <= rel_q[k-1];
        cur_q[k]  <= cur_d;
        len_q[k]  <= len_d;
        lead_q[k] <= lead_d;
        bad_q[k]  <= bad_q[k-1];
      end
    end
  end

  // merge: leaders report their cycle lengths, counted per length
  ppct_pkg::code_t code_d;

  ppct_count #(.POINTS(POINTS)) u_count (
    .len_i  (len_q[POINTS]),
    .lead_i (lead_q[POINTS]),
    .bad_i  (bad_q[POINTS]),
    .code_o (code_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q <= 1'b0;
    end else if (cnt_rdy) begin
      cnt_vld_q <= walk_vld_q[POINTS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_rdy && walk_vld_q[POINTS]) begin
      code_q    <= code_d;
      cnt_bad_q <= bad_q[POINTS];
    end
  end

  // palette compare into the output register
  logic       hit_d;
  logic [1:0] idx_d;

  ppct_match u_match (
    .code_i    (code_q),
    .bad_i     (cnt_bad_q),
    .palette_i (palette_q),
    .hit_o     (hit_d),
    .idx_o     (idx_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_rdy) begin
      out_vld_q <= cnt_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && cnt_vld_q) begin
      out_word_q.cycle_code  <= code_q;
      out_word_q.palette_hit <= hit_d;
      out_word_q.hit_index   <= idx_d;
      out_word_q.bad_perm    <= cnt_bad_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_word_q;

endmodule

/* rtl/core/ppct_front.sv */
module ppct_front #(
  parameter int unsigned POINTS = 10,
  parameter int unsigned IDXW   = $clog2(POINTS)
) (
  input  ppct_pkg::in_word_t          word_i,
  output logic [POINTS-1:0][IDXW-1:0] rel_o,
  output logic                        bad_o
);

  logic [POINTS-1:0][ppct_pkg::NIB_W-1:0] lnib;
  logic [POINTS-1:0][ppct_pkg::NIB_W-1:0] rnib;
  logic [POINTS-1:0][POINTS-1:0]          lhit;
  logic [POINTS-1:0][POINTS-1:0]          rhit;
  logic [POINTS-1:0]                      lcov;
  logic [POINTS-1:0]                      rcov;
  logic [POINTS-1:0][IDXW-1:0]            inv;

  // nibbles past the end of the word read as zero
  for (genvar p = 0; p < POINTS; p++) begin : g_nib
    if (p < ppct_pkg::NIBBLES) begin : g_in
      assign lnib[p] = word_i.left_perm[ppct_pkg::NIB_W*p +: ppct_pkg::NIB_W];
      assign rnib[p] = word_i.right_perm[ppct_pkg::NIB_W*p +: ppct_pkg::NIB_W];
    end else begin : g_pad
      assign lnib[p] = '0;
      assign rnib[p] = '0;
    end
  end

  // one-hot decode of every image; full coverage means a bijection
  always_comb begin
    lcov = '0;
    rcov = '0;
    for (int p = 0; p < POINTS; p++) begin
      for (int q = 0; q < POINTS; q++) begin
        lhit[p][q] = (lnib[p] == ppct_pkg::NIB_W'(q));
        rhit[p][q] = (rnib[p] == ppct_pkg::NIB_W'(q));
      end
      lcov = lcov | lhit[p];
      rcov = rcov | rhit[p];
    end
  end

  assign bad_o = ~(&lcov) | ~(&rcov);

  // inverse of left, then rel[q] = right[inv_left[q]]
  always_comb begin
    for (int q = 0; q < POINTS; q++) begin
      inv[q] = '0;
      for (int p = 0; p < POINTS; p++) begin
        if (lhit[p][q]) inv[q] = inv[q] | IDXW'(p);
      end
    end
    for (int q = 0; q < POINTS; q++) begin
      rel_o[q] = '0;
      for (int p = 0; p < POINTS; p++) begin
        if (!bad_o && inv[q] == IDXW'(p)) rel_o[q] = rel_o[q] | IDXW'(rnib[p]);
      end
    end
  end

endmodule

/* rtl/core/ppct_step.sv */
module ppct_step #(
  parameter int unsigned POINTS = 10,
  parameter int unsigned STEP   = 1,
  parameter int unsigned IDXW   = $clog2(POINTS),
  parameter int unsigned LENW   = $clog2(POINTS + 1)
) (
  input  logic [POINTS-1:0][IDXW-1:0] rel_i,
  input  logic [POINTS-1:0][IDXW-1:0] cur_i,
  input  logic [POINTS-1:0][LENW-1:0] len_i,
  input  logic [POINTS-1:0]           lead_i,
  output logic [POINTS-1:0][IDXW-1:0] cur_o,
  output logic [POINTS-1:0][LENW-1:0] len_o,
  output logic [POINTS-1:0]           lead_o
);

  // every lane follows its own orbit one hop; a lane stays leader only
  // while no smaller point shows up before it returns home
  always_comb begin
    for (int p = 0; p < POINTS; p++) begin
      cur_o[p]  = rel_i[cur_i[p]];
      len_o[p]  = len_i[p];
      lead_o[p] = lead_i[p];
      if (len_i[p] == '0) begin
        if (cur_o[p] == IDXW'(p)) begin
          len_o[p] = LENW'(STEP);
        end else if (cur_o[p] < IDXW'(p)) begin
          lead_o[p] = 1'b0;
        end
      end
    end
  end

endmodule

/* rtl/core/ppct_count.sv */
module ppct_count #(
  parameter int unsigned POINTS = 10,
  parameter int unsigned LENW   = $clog2(POINTS + 1)
) (
  input  logic [POINTS-1:0][LENW-1:0] len_i,
  input  logic [POINTS-1:0]           lead_i,
  input  logic                        bad_i,
  output ppct_pkg::code_t             code_o
);

  localparam int unsigned TW = (4 * (POINTS + 1) > ppct_pkg::CODE_W) ?
                               4 * (POINTS + 1) : ppct_pkg::CODE_W;

  logic [TW-1:0] tmp;
  logic [3:0]    cnt;

  // nibble L of the code is the number of cycles of length L
  always_comb begin
    tmp = '0;
    for (int l = 1; l <= POINTS; l++) begin
      cnt = '0;
      for (int p = 0; p < POINTS; p++) begin
        cnt = cnt + 4'(lead_i[p] && (len_i[p] == LENW'(l)));
      end
      tmp[4*l +: 4] = cnt;
    end
    code_o = bad_i ? '0 : tmp[ppct_pkg::CODE_W-1:0];
  end

endmodule

/* rtl/core/ppct_match.sv */
module ppct_match (
  input  ppct_pkg::code_t                             code_i,
  input  logic                                        bad_i,
  input  logic [ppct_pkg::PALETTE_N-1:0][ppct_pkg::CODE_W-1:0] palette_i,
  output logic                                        hit_o,
  output logic [1:0]                                  idx_o
);

  // lowest matching entry wins
  always_comb begin
    hit_o = 1'b0;
    idx_o = '0;
    for (int k = ppct_pkg::PALETTE_N - 1; k >= 0; k--) begin
      if (!bad_i && palette_i[k] == code_i) begin
        hit_o = 1'b1;
        idx_o = 2'(k);
      end
    end
  end

endmodule

/* test/perm_pair_cycle_type_check_scoreboard.sv */
`timescale 1ns / 100ps
module perm_pair_cycle_type_check_scoreboard #(
  parameter int unsigned POINTS = 10
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  ppct_pkg::in_word_t              in_word_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  ppct_pkg::out_word_t             out_word_i,
  input  logic                            cfg_we_i,
  input  logic [ppct_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ppct_pkg::CODE_W-1:0]     cfg_data_i,
  output int unsigned                     pending_o,
  output int unsigned                     mismatches_o
);
  import ppct_pkg::*;

  code_t       palette [PALETTE_N];
  out_word_t   cycle_type_q [$];
  int unsigned mismatch_count = 0;

  // relative permutation right after inverse of left, then its cycle type
  function automatic out_word_t predict_cycle_type(input in_word_t w);
    logic [NIB_W-1:0]  lft [POINTS];
    logic [NIB_W-1:0]  rgt [POINTS];
    logic [NIB_W-1:0]  inv [POINTS];
    logic [NIB_W-1:0]  rel [POINTS];
    logic [POINTS-1:0] used_l;
    logic [POINTS-1:0] used_r;
    logic [POINTS-1:0] visited;
    out_word_t         res;
    bit                ok;
    int unsigned       p;
    int unsigned       cur;
    int unsigned       len;
    int                k;
    res = '0;
    ok = 1'b1;
    used_l = '0;
    used_r = '0;
    visited = '0;
    for (p = 0; p < POINTS; p++) begin
      lft[p] = w.left_perm[NIB_W*p +: NIB_W];
      rgt[p] = w.right_perm[NIB_W*p +: NIB_W];
      if (lft[p] >= POINTS || rgt[p] >= POINTS) begin
        ok = 1'b0;
      end else begin
        if (used_l[lft[p]] || used_r[rgt[p]]) ok = 1'b0;
        used_l[lft[p]] = 1'b1;
        used_r[rgt[p]] = 1'b1;
      end
    end
    if (!ok) begin
      res.bad_perm = 1'b1;
      return res;
    end
    for (p = 0; p < POINTS; p++) inv[lft[p]] = NIB_W'(p);
    for (p = 0; p < POINTS; p++) rel[p] = rgt[inv[p]];
    for (p = 0; p < POINTS; p++) begin
      if (!visited[p]) begin
        cur = p;
        len = 0;
        do begin
          visited[cur] = 1'b1;
          cur = rel[cur];
          len++;
        end while (cur != p);
        res.cycle_code = res.cycle_code + (code_t'(1) << (NIB_W * len));
      end
    end
    // lowest matching index wins
    for (k = PALETTE_N - 1; k >= 0; k--) begin
      if (palette[k] == res.cycle_code) begin
        res.palette_hit = 1'b1;
        res.hit_index = 2'(k);
      end
    end
    return res;
  endfunction

  task automatic note_mismatch(input string field, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
    mismatch_count++;
    $display("%0d ns: %s expected %h actual %h", $time, field, exp_v, act_v);
  endtask

  task automatic compare_word(input out_word_t exp_w, input out_word_t act_w);
    if (act_w.cycle_code !== exp_w.cycle_code)
      note_mismatch("cycle_code", exp_w.cycle_code, act_w.cycle_code);
    if (act_w.palette_hit !== exp_w.palette_hit)
      note_mismatch("palette_hit", exp_w.palette_hit, act_w.palette_hit);
    if (act_w.hit_index !== exp_w.hit_index)
      note_mismatch("hit_index", exp_w.hit_index, act_w.hit_index);
    if (act_w.bad_perm !== exp_w.bad_perm)
      note_mismatch("bad_perm", exp_w.bad_perm, act_w.bad_perm);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (palette[i]) palette[i] <= '0;
      cycle_type_q.delete();
      pending_o <= 0;
      mismatches_o <= mismatch_count;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (cycle_type_q.size() == 0) begin
          note_mismatch("unexpected word", '0, out_word_i);
        end else begin
          compare_word(cycle_type_q.pop_front(), out_word_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        cycle_type_q.insert(cycle_type_q.size(), predict_cycle_type(in_word_i));
      end
      if (cfg_we_i) palette[cfg_idx_i] <= cfg_data_i;
      pending_o <= cycle_type_q.size();
      mismatches_o <= mismatch_count;
    end
  end

endmodule

/* test/perm_pair_cycle_type_check_tb.sv */
`timescale 1ns / 100ps
module perm_pair_cycle_type_check_tb;
  import ppct_pkg::*;

  localparam int unsigned POINTS = 10;
  // front stage, one hop per point, counting, palette compare
  localparam int unsigned LATENCY = POINTS + 3;
  localparam int unsigned RANDOM_WORDS = 330;

  // palette codes, one bit group per cycle length
  localparam code_t CODE_MAX        = '1;
  localparam code_t IDENT_CODE      = code_t'(POINTS) << 4;
  localparam code_t FULL_CYCLE_CODE = code_t'(1) << (4 * POINTS);
  localparam code_t FIX_NINE_CODE   = (code_t'(1) << 4) | (code_t'(1) << 36);
  localparam code_t ONE_TWO_SEVEN   = (code_t'(1) << 4) | (code_t'(1) << 8) |
                                      (code_t'(1) << 28);
  localparam code_t TWO_EIGHT_CODE  = (code_t'(1) << 8) | (code_t'(1) << 32);
  localparam code_t TRANSP_CODE     = (code_t'(8) << 4) | (code_t'(1) << 8);
  localparam code_t TWO_TRANSP_CODE = (code_t'(6) << 4) | (code_t'(2) << 8);
  localparam code_t THREE_CYC_CODE  = (code_t'(7) << 4) | (code_t'(1) << 12);

  // permutation words, nibble i holds the image of point i
  localparam logic [PERM_W-1:0] IDENT_PERM   = 40'h9876543210;
  localparam logic [PERM_W-1:0] ROT1_PERM    = 40'h0987654321;
  localparam logic [PERM_W-1:0] ROT2_PERM    = 40'h1098765432;
  localparam logic [PERM_W-1:0] REVERSE_PERM = 40'h0123456789;
  localparam logic [PERM_W-1:0] SWAP01_PERM  = 40'h9876543201;
  // cycles of length 1, 2, 3 and 4
  localparam logic [PERM_W-1:0] MIXED_PERM   = 40'h6987354120;
  // broken words: image equal to the point count, nibble 4'hf, a repeat
  localparam logic [PERM_W-1:0] TOP_TEN_PERM = 40'hA876543210;
  localparam logic [PERM_W-1:0] LOW_F_PERM   = 40'h987654321F;
  localparam logic [PERM_W-1:0] DUP_PERM     = 40'h0876543210;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_word_t             in_word;
  logic                 out_valid;
  logic                 out_stall;
  out_word_t            out_word;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  code_t                cfg_data;
  int unsigned          pending;
  int unsigned          mismatches;

  // idle mode per stretch of words: 7 gives random gaps, 0 runs back to back
  int unsigned send_max_gap;
  int unsigned recv_max_stall;
  int unsigned stall_cycles;
  int unsigned words_taken;

  perm_pair_cycle_type_check #(
    .POINTS (POINTS)
  ) uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  // watches all three ports, predicts each result and compares
  perm_pair_cycle_type_check_scoreboard #(
    .POINTS (POINTS)
  ) u_score (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_word_i    (in_word),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_word_i   (out_word),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .pending_o    (pending),
    .mismatches_o (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop, far beyond the slowest correct run
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

  // uniform random permutation of the points
  function automatic logic [PERM_W-1:0] shuffled_perm();
    logic [NIB_W-1:0]  pts [POINTS];
    logic [NIB_W-1:0]  tmp;
    logic [PERM_W-1:0] w;
    int unsigned       i;
    int unsigned       j;
    for (i = 0; i < POINTS; i++) pts[i] = NIB_W'(i);
    for (i = POINTS - 1; i > 0; i--) begin
      j = $urandom_range(i, 0);
      tmp = pts[i];
      pts[i] = pts[j];
      pts[j] = tmp;
    end
    w = '0;
    for (i = 0; i < POINTS; i++) w[NIB_W*i +: NIB_W] = pts[i];
    return w;
  endfunction

  // a few random swaps keep the relative permutation close to identity
  function automatic logic [PERM_W-1:0] swap_points(input logic [PERM_W-1:0] w,
                                                    input int unsigned swaps);
    logic [NIB_W-1:0] tmp;
    int unsigned      i;
    int unsigned      j;
    repeat (swaps) begin
      i = $urandom_range(POINTS - 1, 0);
      j = $urandom_range(POINTS - 1, 0);
      tmp = w[NIB_W*i +: NIB_W];
      w[NIB_W*i +: NIB_W] = w[NIB_W*j +: NIB_W];
      w[NIB_W*j +: NIB_W] = tmp;
    end
    return w;
  endfunction

  // out of range image or a repeated image at one point
  function automatic logic [PERM_W-1:0] corrupt_perm(input logic [PERM_W-1:0] w);
    int unsigned i;
    int unsigned j;
    i = $urandom_range(POINTS - 1, 0);
    j = (i + $urandom_range(POINTS - 1, 1)) % POINTS;
    if ($urandom_range(1, 0) == 1) w[NIB_W*i +: NIB_W] = NIB_W'($urandom_range(15, POINTS));
    else w[NIB_W*i +: NIB_W] = w[NIB_W*j +: NIB_W];
    return w;
  endfunction

  // valid stays up between back to back words, lowered only for a gap
  task automatic send_word(input logic [PERM_W-1:0] lft, input logic [PERM_W-1:0] rgt);
    int unsigned gap;
    gap = $urandom_range(send_max_gap, 0);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= '{left_perm: lft, right_perm: rgt};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input code_t data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic load_palette(input code_t c0, input code_t c1, input code_t c2,
                              input code_t c3);
    cfg_write(CFG_PALETTE_0, c0);
    cfg_write(CFG_PALETTE_1, c1);
    cfg_write(CFG_PALETTE_2, c2);
    cfg_write(CFG_PALETTE_3, c3);
    cfg_we <= 1'b0;
  endtask

  // let the clock tick first so the last accepted word shows up in the pending count
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // mostly well formed pairs, some near identity, the rest broken or noise
  task automatic random_phase();
    logic [PERM_W-1:0] lft;
    logic [PERM_W-1:0] rgt;
    logic [63:0]       noise;
    int unsigned       pick;
    int unsigned       n;
    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 64 == 0) send_max_gap = ($urandom_range(3, 0) == 0) ? 0 : 7;
      lft = shuffled_perm();
      rgt = shuffled_perm();
      pick = $urandom_range(99, 0);
      if (pick >= 35 && pick < 75) begin
        rgt = swap_points(lft, $urandom_range(3, 0));
      end else if (pick >= 75 && pick < 88) begin
        if ($urandom_range(1, 0) == 1) lft = corrupt_perm(lft);
        else rgt = corrupt_perm(rgt);
      end else if (pick >= 88) begin
        noise = {$urandom, $urandom};
        lft = noise[PERM_W-1:0];
        noise = {$urandom, $urandom};
        rgt = noise[PERM_W-1:0];
      end
      send_word(lft, rgt);
    end
  endtask

  // result side: random stall before each word, some stretches never stall
  initial begin
    out_stall <= 1'b0;
    recv_max_stall = 7;
    words_taken = 0;
    @(posedge rst_n);
    forever begin
      stall_cycles = $urandom_range(recv_max_stall, 0);
      if (stall_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (stall_cycles) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      words_taken++;
      if (words_taken % 64 == 0) recv_max_stall = ($urandom_range(3, 0) == 0) ? 0 : 7;
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_word <= '0;
    cfg_we <= 1'b0;
    cfg_idx <= CFG_PALETTE_0;
    cfg_data <= '0;
    send_max_gap = 7;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // palette still at reset: zero must never hit, not even for a bad pair
    send_word(IDENT_PERM, IDENT_PERM);
    send_word('0, '0);
    drain();

    // directed words: identity, full cycle, unmatched types, broken inputs
    load_palette(IDENT_CODE, FULL_CYCLE_CODE, CODE_MAX, '0);
    send_word(IDENT_PERM, IDENT_PERM);
    send_word(MIXED_PERM, MIXED_PERM);
    send_word(IDENT_PERM, ROT1_PERM);
    send_word(ROT1_PERM, IDENT_PERM);
    send_word(ROT1_PERM, ROT2_PERM);
    send_word(IDENT_PERM, SWAP01_PERM);
    send_word(IDENT_PERM, REVERSE_PERM);
    send_word(REVERSE_PERM, MIXED_PERM);
    send_word(IDENT_PERM, MIXED_PERM);
    send_word('0, '0);
    send_word('1, '1);
    send_word(TOP_TEN_PERM, IDENT_PERM);
    send_word(IDENT_PERM, TOP_TEN_PERM);
    send_word(LOW_F_PERM, ROT1_PERM);
    send_word(ROT2_PERM, DUP_PERM);
    send_word(DUP_PERM, DUP_PERM);
    send_word(MIXED_PERM, '1);
    send_word('1, REVERSE_PERM);
    drain();

    // common cycle types of random pairs, one per register
    load_palette(FIX_NINE_CODE, FULL_CYCLE_CODE, ONE_TWO_SEVEN, TWO_EIGHT_CODE);
    random_phase();
    drain();

    // near identity types, with a repeated code that must report the lower index
    load_palette(TRANSP_CODE, TWO_TRANSP_CODE, TWO_TRANSP_CODE, THREE_CYC_CODE);
    random_phase();
    drain();

    // extremes: zero and all ones never match, identity only on the top register
    load_palette('0, CODE_MAX, CODE_MAX, IDENT_CODE);
    random_phase();
    drain();

    // catch stray words after the last expected one
    repeat (2 * LATENCY) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/ppct_pkg.sv
rtl/core/ppct_front.sv
rtl/core/ppct_step.sv
rtl/core/ppct_count.sv
rtl/core/ppct_match.sv
rtl/core/perm_pair_cycle_type_check.sv
test/perm_pair_cycle_type_check_scoreboard.sv
test/perm_pair_cycle_type_check_tb.sv
